>>> design/rtpd_pkg.sv
// ----------------------------------------------------------------------------
// rtpd_pkg
// Types and constants shared by the RTP to H.264 Annex B depacketizer.
// ----------------------------------------------------------------------------
package rtpd_pkg;

   // One packet byte as it arrives
   typedef struct packed {
      logic [7:0] pkt_byte;
      logic       pkt_last;
   } req_type;

   // One Annex B stream byte as it leaves
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       chunk_end;
   } rsp_type;

   // Work handed from the classifier to the emitter
   typedef struct packed {
      logic [7:0] data;    // byte to write after the optional start code
      logic       start;   // prefix 00 00 00 01
      logic       last;    // request carried the packet end mark
   } job_type;

   // Packet handling state
   typedef enum logic [3:0] {
      KIND_HEADER = 4'b0001,
      KIND_PASS   = 4'b0010,
      KIND_FUHDR  = 4'b0100,
      KIND_DROP   = 4'b1000
   } kind_type;

   // SPS / PPS / IDR gate state
   typedef enum logic [3:0] {
      GATE_NONE   = 4'b0001,
      GATE_SPS    = 4'b0010,
      GATE_PPS    = 4'b0100,
      GATE_PASSED = 4'b1000
   } gate_type;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_AUDIO_PT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_IDR = 1'd1;

   localparam logic [6:0] AUDIO_PT_RESET = 7'd97;

   // Byte positions within a packet
   localparam logic [3:0] POS_PT     = 4'd1;
   localparam logic [3:0] HDR_LEN    = 4'd12;
   localparam logic [3:0] POS_MAX    = 4'd14;

   // NAL unit types
   localparam logic [4:0] NT_IDR     = 5'd5;
   localparam logic [4:0] NT_SPS     = 5'd7;
   localparam logic [4:0] NT_PPS     = 5'd8;
   localparam logic [4:0] NT_SINGLE_MAX = 5'd23;
   localparam logic [4:0] NT_AGG_MAX = 5'd27;
   localparam logic [4:0] NT_FUA     = 5'd28;
   localparam logic [4:0] NT_INVALID = 5'd30;

endpackage

>>> design/rtpd_front.sv
// ----------------------------------------------------------------------------
// rtpd_front
// Packet classifier: tracks the byte position, drops audio and unsupported
// packets, runs the SPS/PPS/IDR gate and hands one job per output burst on.
// ----------------------------------------------------------------------------
module rtpd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   input  rtpd_pkg::req_type                  req_data,
   input  logic                               q_full,
   output logic                               job_push,
   output rtpd_pkg::job_type                  job_data,
   input  logic                               csr_write,
   input  logic [rtpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rtpd_pkg::CSR_DATA_W-1:0]    csr_data
);
   import rtpd_pkg::*;

   logic [6:0] audio_pt_ff, audio_pt_in;
   logic       wait_idr_ff, wait_idr_in;
   logic [3:0] pos_ff, pos_in;
   kind_type   kind_ff, kind_in;
   logic [2:0] ind_ff, ind_in;
   gate_type   gate_ff, gate_in;
   logic       sps_ff, sps_in;

   logic       accept;
   logic [7:0] b;
   logic [4:0] nal_type;
   logic       pass;

   assign accept   = req_push && !q_full;
   assign b        = req_data.pkt_byte;
   assign nal_type = b[4:0];

   // Classify the accepted request and advance packet state
   always_comb begin
      audio_pt_in = audio_pt_ff;
      wait_idr_in = wait_idr_ff;
      pos_in      = pos_ff;
      kind_in     = kind_ff;
      ind_in      = ind_ff;
      gate_in     = gate_ff;
      sps_in      = sps_ff;
      pass        = 1'b1;
      job_push    = 1'b0;
      job_data.data  = b;
      job_data.start = 1'b0;
      job_data.last  = req_data.pkt_last;

      if (accept) begin
         if (kind_ff == KIND_DROP) begin
            // hold: rest of packet discarded
         end else if (pos_ff < HDR_LEN) begin
            if (pos_ff == POS_PT && b[6:0] == audio_pt_ff) begin
               kind_in = KIND_DROP;
            end
         end else if (pos_ff == HDR_LEN) begin
            if (nal_type >= NT_INVALID) begin
               kind_in = KIND_DROP;
            end else begin
               // gate check
               if (gate_ff == GATE_PASSED) begin
                  pass = 1'b1;
               end else if (nal_type == NT_SPS) begin
                  gate_in = GATE_SPS;
               end else if (nal_type == NT_PPS && gate_ff == GATE_SPS) begin
                  gate_in = GATE_PPS;
                  sps_in  = 1'b1;
               end else if ((nal_type == NT_IDR || nal_type == NT_FUA) &&
                            gate_ff == GATE_PPS && sps_ff) begin
                  gate_in = GATE_PASSED;
               end else begin
                  gate_in = GATE_NONE;
                  sps_in  = 1'b0;
                  pass    = 1'b0;
               end

               if (!pass) begin
                  kind_in = KIND_DROP;
               end else if (nal_type <= NT_SINGLE_MAX) begin
                  job_push       = 1'b1;
                  job_data.start = 1'b1;
                  kind_in        = KIND_PASS;
               end else if (nal_type <= NT_AGG_MAX) begin
                  kind_in = KIND_DROP;
               end else begin
                  ind_in  = b[7:5];
                  kind_in = KIND_FUHDR;
               end
            end
         end else if (kind_ff == KIND_FUHDR) begin
            if (b[7] && b[6]) begin
               kind_in = KIND_DROP;
            end else begin
               if (b[7]) begin
                  job_push       = 1'b1;
                  job_data.start = 1'b1;
                  job_data.data  = {ind_ff, nal_type};
               end
               kind_in = KIND_PASS;
            end
         end else if (kind_ff == KIND_PASS) begin
            job_push = 1'b1;
         end

         // advance or rewind position
         if (req_data.pkt_last) begin
            pos_in  = '0;
            kind_in = KIND_HEADER;
            ind_in  = '0;
         end else if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + 4'd1;
         end
      end

      // register writes; a gate mode write restarts the gate
      if (csr_write) begin
         case (csr_index)
            CSR_AUDIO_PT: audio_pt_in = csr_data;
            CSR_WAIT_IDR: begin
               wait_idr_in = csr_data[0];
               gate_in     = csr_data[0] ? GATE_NONE : GATE_PASSED;
               sps_in      = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         audio_pt_ff <= AUDIO_PT_RESET;
         wait_idr_ff <= 1'b0;
         pos_ff      <= '0;
         kind_ff     <= KIND_HEADER;
         ind_ff      <= '0;
         gate_ff     <= GATE_PASSED;
         sps_ff      <= 1'b0;
      end else begin
         audio_pt_ff <= audio_pt_in;
         wait_idr_ff <= wait_idr_in;
         pos_ff      <= pos_in;
         kind_ff     <= kind_in;
         ind_ff      <= ind_in;
         gate_ff     <= gate_in;
         sps_ff      <= sps_in;
      end
   end

endmodule

>>> design/rtpd_queue.sv
// ----------------------------------------------------------------------------
// rtpd_queue
// Small first-in first-out queue of jobs between classifier and emitter.
// ----------------------------------------------------------------------------
module rtpd_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rtpd_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output rtpd_pkg::job_type head_data,
   output logic              empty
);
   import rtpd_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/rtpd_back.sv
// ----------------------------------------------------------------------------
// rtpd_back
// Emitter: expands each job into an optional 00 00 00 01 start code and the
// job byte, one stream byte per popped request.
// ----------------------------------------------------------------------------
module rtpd_back (
   input  logic              clock,
   input  logic              reset,
   input  rtpd_pkg::job_type head_data,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rtpd_pkg::rsp_type rsp_data
);
   import rtpd_pkg::*;

   localparam logic [2:0] PHASE_FIRST = 3'd0;
   localparam logic [2:0] PHASE_ONE   = 3'd3;
   localparam logic [2:0] PHASE_DATA  = 3'd4;

   job_type    job_ff, job_in;
   logic       valid_ff, valid_in;
   logic [2:0] phase_ff, phase_in;
   logic       load;

   // Take a new job when idle or when the final byte of this one leaves
   assign load  = !valid_ff || (rsp_pop && phase_ff == PHASE_DATA);
   assign q_pop = load && !q_empty;

   always_comb begin
      job_in   = job_ff;
      valid_in = valid_ff;
      phase_in = phase_ff;
      if (load) begin
         valid_in = !q_empty;
         job_in   = head_data;
         phase_in = head_data.start ? PHASE_FIRST : PHASE_DATA;
      end else if (rsp_pop) begin
         phase_in = phase_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= PHASE_FIRST;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   // Present the current stream byte
   assign rsp_empty          = !valid_ff;
   assign rsp_data.out_byte  = (phase_ff == PHASE_DATA) ? job_ff.data :
                               (phase_ff == PHASE_ONE) ? 8'h01 : 8'h00;
   assign rsp_data.run_last  = (phase_ff == PHASE_DATA);
   assign rsp_data.chunk_end = (phase_ff == PHASE_DATA) && job_ff.last;

endmodule

>>> design/rtp_h264_depacketizer_top.sv
// ----------------------------------------------------------------------------
// rtp_h264_depacketizer_top
// RTP packet bytes in, H.264 Annex B byte stream out.
// ----------------------------------------------------------------------------
// Usage:
//   Request side: push one packet byte with its end mark while full is low.
//   The 12-byte RTP header is skipped; audio, aggregate and malformed
//   fragment packets are discarded.
//   Response side: while empty is low the oldest stream byte sits on rsp_data;
//   pop takes it. A packet byte that produces output passes through the job
//   queue and the emitter register before it appears on rsp_data.
//   Throughput: one packet byte per cycle while full is low. A NAL start
//   emits five stream bytes (start code plus header) from one request; the
//   job queue of QUEUE_DEPTH entries absorbs the burst, and full rises once
//   it fills.
//   A stalled receiver holds the current byte; the queue then fills and full
//   stops the request side.
//   Configuration: write via csr_valid, always ready, only while idle.
//   Reset clears the queue and the emitter and restores the registers.
// ----------------------------------------------------------------------------
module rtp_h264_depacketizer_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  rtpd_pkg::req_type                  req_data,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output rtpd_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rtpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rtpd_pkg::CSR_DATA_W-1:0]    csr_data
);
   import rtpd_pkg::*;

   job_type job_data;
   job_type head_data;
   logic    job_push;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;

   // Classify requests
   rtpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .q_full    (q_full),
      .job_push  (job_push),
      .job_data  (job_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Decouple classifier from emitter
   rtpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .full      (q_full),
      .pop       (q_pop),
      .head_data (head_data),
      .empty     (q_empty)
   );

   // Emit stream bytes
   rtpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (head_data),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

>>> design/rtpd_checker.sv
// ----------------------------------------------------------------------------
// rtpd_checker
// Port-level checks on the depacketizer's response stream.
// ----------------------------------------------------------------------------
module rtpd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input rtpd_pkg::rsp_type rsp_data
);
   import rtpd_pkg::*;

   // Nothing waits straight after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("response waiting after reset");

   // Packet end is only marked on the last byte of a burst
   a_chunk_on_run_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.chunk_end) |-> rsp_data.run_last)
      else $error("chunk_end without run_last");

   // Bytes before the last of a burst belong to the start code
   a_start_code_bytes: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.run_last) |->
      (rsp_data.out_byte == 8'h00 || rsp_data.out_byte == 8'h01))
      else $error("unexpected byte inside start code");

   // A burst continues without gaps
   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.run_last) |=> !rsp_empty)
      else $error("gap inside output burst");

   // A stalled response holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind rtp_h264_depacketizer_top rtpd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

>>> dv/rtp_h264_depacketizer_checker.sv
// ----------------------------------------------------------------------------
// rtp_h264_depacketizer_checker
// Watches the packet, stream and register channels of the depacketizer,
// predicts the Annex B byte stream from the accepted packet bytes and
// compares every popped stream byte with the oldest predicted one.
// ----------------------------------------------------------------------------
module rtp_h264_depacketizer_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   input  logic                               req_full,
   input  rtpd_pkg::req_type                  req_data,
   input  logic                               rsp_empty,
   input  logic                               rsp_pop,
   input  rtpd_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [rtpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rtpd_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                 error_count,
   output int                                 pending_count,
   output int                                 checked_count
);
   import rtpd_pkg::*;

   localparam logic [31:0] START_CODE = 32'h0000_0001;

   // Shadow registers and depacketizer state
   logic [6:0]  audio_pt;
   logic        wait_idr;
   logic [3:0]  byte_pos;
   kind_type    kind;
   logic [2:0]  fu_nri;
   gate_type    gate;
   logic        sps_flag;

   // Stream bytes caused by the current request, and all still owed
   logic [7:0]  nal_bytes[$];
   rsp_type     expected_stream[$];

   initial begin
      error_count = 0;
      pending_count = 0;
      checked_count = 0;
   end

   // Step the SPS / PPS / IDR gate for one NAL type
   task automatic advance_gate(input logic [4:0] nal_type, output logic admit);
      admit = 1'b1;
      if (gate != GATE_PASSED) begin
         if (nal_type == NT_SPS) begin
            gate = GATE_SPS;
         end else if (nal_type == NT_PPS && gate == GATE_SPS) begin
            gate = GATE_PPS;
            sps_flag = 1'b1;
         end else if ((nal_type == NT_IDR || nal_type == NT_FUA) &&
                      gate == GATE_PPS && sps_flag) begin
            gate = GATE_PASSED;
         end else begin
            gate = GATE_NONE;
            sps_flag = 1'b0;
            admit = 1'b0;
         end
      end
   endtask

   // Start code followed by a NAL header
   task automatic push_nal_start(input logic [7:0] nal_hdr);
      nal_bytes.push_back(START_CODE[31:24]);
      nal_bytes.push_back(START_CODE[23:16]);
      nal_bytes.push_back(START_CODE[15:8]);
      nal_bytes.push_back(START_CODE[7:0]);
      nal_bytes.push_back(nal_hdr);
   endtask

   // Work out the stream bytes one packet byte causes
   task automatic predict_stream_bytes(input req_type rq);
      logic [4:0] nal_type;
      logic       admit;
      rsp_type    item;
      nal_bytes.delete();
      nal_type = rq.pkt_byte[4:0];
      if (kind == KIND_DROP) begin
         // discard the rest of the packet
      end else if (byte_pos < HDR_LEN) begin
         if (byte_pos == POS_PT && rq.pkt_byte[6:0] == audio_pt) begin
            kind = KIND_DROP;
         end
      end else if (byte_pos == HDR_LEN) begin
         if (nal_type >= NT_INVALID) begin
            kind = KIND_DROP;
         end else begin
            advance_gate(nal_type, admit);
            if (!admit) begin
               kind = KIND_DROP;
            end else if (nal_type <= NT_SINGLE_MAX) begin
               push_nal_start(rq.pkt_byte);
               kind = KIND_PASS;
            end else if (nal_type <= NT_AGG_MAX) begin
               kind = KIND_DROP;
            end else begin
               fu_nri = rq.pkt_byte[7:5];
               kind = KIND_FUHDR;
            end
         end
      end else if (kind == KIND_FUHDR) begin
         // S and E both set makes the fragment invalid
         if (rq.pkt_byte[7] && rq.pkt_byte[6]) begin
            kind = KIND_DROP;
         end else begin
            if (rq.pkt_byte[7]) begin
               push_nal_start({fu_nri, rq.pkt_byte[4:0]});
            end
            kind = KIND_PASS;
         end
      end else if (kind == KIND_PASS) begin
         nal_bytes.push_back(rq.pkt_byte);
      end

      for (int i = 0; i < nal_bytes.size(); i++) begin
         item.out_byte = nal_bytes[i];
         item.run_last = (i == nal_bytes.size() - 1);
         item.chunk_end = item.run_last & rq.pkt_last;
         expected_stream.push_back(item);
      end

      // Rewind at packet end, else advance the saturating position
      if (rq.pkt_last) begin
         byte_pos = '0;
         kind = KIND_HEADER;
         fu_nri = '0;
      end else if (byte_pos < POS_MAX) begin
         byte_pos = byte_pos + 4'd1;
      end
   endtask

   // Compare one popped stream byte with the oldest prediction
   task automatic check_stream_byte(input rsp_type got);
      rsp_type want;
      if (expected_stream.size() == 0) begin
         error_count++;
         $display("%0t: unexpected stream byte, expected none, actual %h/%b/%b",
                  $time, got.out_byte, got.run_last, got.chunk_end);
      end else begin
         want = expected_stream.pop_front();
         checked_count++;
         if (got.out_byte !== want.out_byte) begin
            error_count++;
            $display("%0t: out_byte mismatch, expected %h, actual %h",
                     $time, want.out_byte, got.out_byte);
         end
         if (got.run_last !== want.run_last) begin
            error_count++;
            $display("%0t: run_last mismatch, expected %b, actual %b",
                     $time, want.run_last, got.run_last);
         end
         if (got.chunk_end !== want.chunk_end) begin
            error_count++;
            $display("%0t: chunk_end mismatch, expected %b, actual %b",
                     $time, want.chunk_end, got.chunk_end);
         end
      end
   endtask

   // Sample all three channels on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         audio_pt = AUDIO_PT_RESET;
         wait_idr = 1'b0;
         byte_pos = '0;
         kind = KIND_HEADER;
         fu_nri = '0;
         gate = GATE_PASSED;
         sps_flag = 1'b0;
         expected_stream.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_AUDIO_PT) begin
               audio_pt = csr_data[6:0];
            end else if (csr_index == CSR_WAIT_IDR) begin
               wait_idr = csr_data[0];
               gate = wait_idr ? GATE_NONE : GATE_PASSED;
               sps_flag = 1'b0;
            end
         end
         if (req_push && !req_full) begin
            predict_stream_bytes(req_data);
         end
         if (rsp_pop && !rsp_empty) begin
            check_stream_byte(rsp_data);
         end
      end
      pending_count = expected_stream.size();
   end

endmodule

>>> dv/tb_rtp_h264_depacketizer_top.sv
// ----------------------------------------------------------------------------
// tb_rtp_h264_depacketizer_top
// Packet stimulus and verdict for the RTP to Annex B depacketizer.
// Directed packets cover single NAL units, FU-A / FU-B fragments, audio,
// aggregate and reserved types, short packets and the SPS / PPS / IDR gate;
// a few random packets under other register settings close the run, with
// idle bursts on both sides and then none. The checker beside the block
// predicts and compares the stream.
// ----------------------------------------------------------------------------
module tb_rtp_h264_depacketizer_top;
   import rtpd_pkg::*;

   localparam logic [4:0] NT_SLICE    = 5'd1;
   localparam logic [4:0] NT_STAP_A   = 5'd24;
   localparam logic [4:0] NT_FUB      = 5'd29;
   localparam logic [4:0] NT_RSVD_TOP = 5'd31;
   localparam int DRAIN_SLACK = 12;
   localparam int HOLD_CYCLES = 80;
   localparam int HOLD_BODY   = 10;
   localparam int ITEM_TARGET = 210;
   localparam int CALM_ITEMS  = 15;

   logic                     clock;
   logic                     reset;
   logic                     req_push;
   logic                     req_full;
   req_type                  req_data;
   logic                     rsp_empty;
   logic                     rsp_pop;
   rsp_type                  rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_data;

   int error_count;
   int pending_count;
   int checked_count;

   // Stimulus bookkeeping
   bit         calm;
   bit         hold_rsp;
   logic [6:0] audio_pt_cfg;
   logic [7:0] pkt[$];
   int         items_sent;
   int         packets_sent;
   int         settings_used;

   rtp_h264_depacketizer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   rtp_h264_depacketizer_checker stream_checker (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data      (req_data),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit, far beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Receiver: random stall bursts, one long hold-off on request
   initial begin
      rsp_pop = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge clock);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   function automatic logic [6:0] pick_pt();
      logic [6:0] pt;
      pt = 7'($urandom_range(0, 127));
      while (pt == audio_pt_cfg) pt = 7'($urandom_range(0, 127));
      return pt;
   endfunction

   function automatic int body_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
      return $urandom_range(0, 4);
   endfunction

   // Fresh packet holding a random 12-byte RTP header
   task automatic start_packet(input logic [6:0] pt);
      logic [7:0] b;
      logic       marker;
      pkt.delete();
      b = 8'($urandom);
      pkt.push_back(b);
      marker = 1'($urandom_range(0, 1));
      pkt.push_back({marker, pt});
      repeat (10) begin
         b = 8'($urandom);
         pkt.push_back(b);
      end
   endtask

   task automatic add_body(input int n);
      logic [7:0] b;
      repeat (n) begin
         b = 8'($urandom);
         pkt.push_back(b);
      end
   endtask

   // Offer the packet byte by byte, with random gaps
   task automatic send_packet();
      req_type next_req;
      for (int i = 0; i < pkt.size(); i++) begin
         if (!calm && $urandom_range(0, 5) == 0) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         next_req.pkt_byte = pkt[i];
         next_req.pkt_last = (i == pkt.size() - 1);
         req_data <= next_req;
         req_push <= 1'b1;
         @(posedge clock);
         while (req_full) @(posedge clock);
         @(negedge clock);
         items_sent++;
      end
      packets_sent++;
   endtask

   task automatic send_single(input logic [6:0] pt, input logic [7:0] nal_hdr,
                              input int n);
      start_packet(pt);
      pkt.push_back(nal_hdr);
      add_body(n);
      send_packet();
   endtask

   task automatic send_fu(input logic [6:0] pt, input logic [7:0] indicator,
                          input logic [7:0] fu_hdr, input int n);
      start_packet(pt);
      pkt.push_back(indicator);
      pkt.push_back(fu_hdr);
      add_body(n);
      send_packet();
   endtask

   // Hold the sender until every predicted byte has come out
   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_SLACK) @(negedge clock);
   endtask

   // Write both registers while the block is idle
   task automatic configure(input logic [6:0] pt, input logic idr);
      logic [5:0] junk;
      wait_drained();
      junk = 6'($urandom);
      csr_index <= CSR_AUDIO_PT;
      csr_data <= pt;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_index <= CSR_WAIT_IDR;
      csr_data <= {junk, idr};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      audio_pt_cfg = pt;
      settings_used++;
   endtask

   // One random packet, mostly well formed
   task automatic send_random_packet();
      int         sel;
      int         len;
      logic [4:0] nal_type;
      logic [2:0] nri;
      logic [7:0] fu_hdr;
      logic [7:0] b;
      sel = $urandom_range(0, 99);
      nri = 3'($urandom);
      fu_hdr = 8'($urandom);
      if (sel < 30) begin
         case ($urandom_range(0, 3))
            0: nal_type = 5'($urandom_range(0, NT_SINGLE_MAX));
            1: nal_type = NT_SPS;
            2: nal_type = NT_PPS;
            default: nal_type = NT_IDR;
         endcase
         send_single(pick_pt(), {nri, nal_type}, body_len());
      end else if (sel < 60) begin
         nal_type = $urandom_range(0, 1) ? NT_FUA : NT_FUB;
         case ($urandom_range(0, 2))
            0: fu_hdr[7:6] = 2'b10;
            1: fu_hdr[7:6] = 2'b00;
            default: fu_hdr[7:6] = 2'b01;
         endcase
         send_fu(pick_pt(), {nri, nal_type}, fu_hdr, body_len());
      end else if (sel < 72) begin
         // gate opening sequence, now and then with a step missing
         if ($urandom_range(0, 4) != 0) send_single(pick_pt(), {nri, NT_SPS}, body_len());
         if ($urandom_range(0, 4) != 0) send_single(pick_pt(), {nri, NT_PPS}, body_len());
         if ($urandom_range(0, 1) == 0) begin
            send_single(pick_pt(), {nri, NT_IDR}, body_len());
         end else begin
            fu_hdr[7:6] = 2'b10;
            send_fu(pick_pt(), {nri, NT_FUA}, fu_hdr, body_len());
         end
      end else if (sel < 76) begin
         nal_type = 5'($urandom);
         send_single(audio_pt_cfg, {nri, nal_type}, body_len());
      end else if (sel < 81) begin
         nal_type = 5'($urandom_range(NT_STAP_A, NT_AGG_MAX));
         send_single(pick_pt(), {nri, nal_type}, body_len());
      end else if (sel < 85) begin
         nal_type = 5'($urandom_range(NT_INVALID, NT_RSVD_TOP));
         send_single(pick_pt(), {nri, nal_type}, body_len());
      end else if (sel < 89) begin
         fu_hdr[7:6] = 2'b11;
         nal_type = $urandom_range(0, 1) ? NT_FUA : NT_FUB;
         send_fu(pick_pt(), {nri, nal_type}, fu_hdr, body_len());
      end else if (sel < 95) begin
         // short packet, possibly a bare FU indicator
         len = $urandom_range(1, 13);
         start_packet(7'($urandom_range(0, 127)));
         while (pkt.size() > len) void'(pkt.pop_back());
         if (len == 13) pkt.push_back({nri, NT_FUA});
         send_packet();
      end else begin
         pkt.delete();
         len = $urandom_range(1, 20);
         repeat (len) begin
            b = 8'($urandom);
            pkt.push_back(b);
         end
         send_packet();
      end
   endtask

   // Random packets until the running byte total reaches the given mark
   task automatic run_random_phase(input int item_mark);
      send_random_packet();
      while (items_sent < item_mark) send_random_packet();
   endtask

   // Main sequence
   initial begin
      int drain_cycles;
      logic [6:0] rand_pt;
      logic       rand_idr;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      calm = 1'b0;
      hold_rsp = 1'b0;
      audio_pt_cfg = AUDIO_PT_RESET;
      items_sent = 0;
      packets_sent = 0;
      settings_used = 1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed packets under the reset settings
      send_single(pick_pt(), {3'b000, NT_SINGLE_MAX}, 0);
      send_single(AUDIO_PT_RESET, {3'b011, NT_IDR}, 0);
      send_fu(pick_pt(), {3'b011, NT_FUA}, {3'b100, NT_IDR}, 1);
      send_fu(pick_pt(), {3'b110, NT_FUB}, {3'b010, NT_SLICE}, 1);
      send_fu(pick_pt(), {3'b011, NT_FUA}, {3'b110, NT_IDR}, 0);
      // start fragment whose FU header is the last byte
      send_fu(pick_pt(), {3'b111, NT_FUA}, {3'b101, 5'h1F}, 0);
      // short packets
      start_packet(pick_pt());
      while (pkt.size() > 5) void'(pkt.pop_back());
      send_packet();
      start_packet(pick_pt());
      pkt.push_back({3'b011, NT_FUA});
      send_packet();

      // Gate directed: aggregate resets the gate, reserved type leaves it
      configure(7'd0, 1'b1);
      send_single(7'd5, {3'b011, NT_STAP_A}, 0);
      send_single(7'd5, {3'b011, NT_SPS}, 0);
      send_single(7'd5, {3'b011, NT_INVALID}, 0);
      send_single(7'd5, {3'b011, NT_PPS}, 0);
      send_fu(7'd5, {3'b011, NT_FUA}, {3'b100, NT_IDR}, 0);

      // Receiver holds off while a NAL unit fills the block
      configure(7'd127, 1'b0);
      hold_rsp = 1'b1;
      send_single(pick_pt(), {3'b011, NT_IDR}, HOLD_BODY);
      wait_drained();

      // Random packets under random settings
      rand_pt = 7'($urandom);
      rand_idr = 1'($urandom);
      configure(rand_pt, rand_idr);
      run_random_phase(ITEM_TARGET - CALM_ITEMS);

      // Last stretch at full rate on both sides
      rand_pt = 7'($urandom);
      configure(rand_pt, 1'b0);
      calm = 1'b1;
      run_random_phase(ITEM_TARGET);

      req_push <= 1'b0;
      drain_cycles = 0;
      while (pending_count != 0 && drain_cycles < 100_000) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (DRAIN_SLACK) @(negedge clock);

      $display("Sent %0d packets (%0d bytes) over %0d register settings; %0d stream bytes compared.",
               packets_sent, items_sent, settings_used, checked_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> files.f
design/rtpd_pkg.sv
design/rtpd_front.sv
design/rtpd_queue.sv
design/rtpd_back.sv
design/rtp_h264_depacketizer_top.sv
design/rtpd_checker.sv
dv/rtp_h264_depacketizer_checker.sv
dv/tb_rtp_h264_depacketizer_top.sv
